// ===== design/beqsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Breakpoint equaliser package
// Shared widths, register indexes, status codes and the control and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package beqsg_pkg;

  localparam int MaxFftLen = 4096;
  localparam int MaxPoints = 64;

  localparam int FreqW  = 25;
  localparam int GainW  = 16;
  localparam int SpecW  = 24;
  localparam int BinW   = 12;
  localparam int LogW   = 4;
  localparam int StatW  = 3;
  localparam int OpW    = 1;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 25;

  // Divider produces one quotient bit per step.
  localparam int DivSteps = GainW;

  localparam logic [GainW-1:0] OneQ12 = 16'h1000;

  localparam logic [CfgIdxW-1:0] CFG_FFT_LEN_LOG2 = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIN_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COMPLEX_MODE = 2'd2;

  localparam logic [LogW-1:0]  RstFftLenLog2 = 4'd9;
  localparam logic [FreqW-1:0] RstBinWidth   = 25'd22050;
  localparam logic             RstComplex    = 1'b0;

  localparam logic [LogW-1:0]  MinFftLog = 4'd6;

  localparam logic [OpW-1:0] OP_LOAD = 1'b0;
  localparam logic [OpW-1:0] OP_BIN  = 1'b1;

  localparam logic [StatW-1:0] ST_OK        = 3'd0;
  localparam logic [StatW-1:0] ST_FEW       = 3'd1;
  localparam logic [StatW-1:0] ST_ORDER     = 3'd2;
  localparam logic [StatW-1:0] ST_MANY      = 3'd3;
  localparam logic [StatW-1:0] ST_BIN_RANGE = 3'd4;

  typedef enum logic [1:0] {
    WSEL_FILL,
    WSEL_LEFT,
    WSEL_RIGHT
  } tbl_wsel_e;

  typedef struct packed {
    logic      in_latch;
    logic      pt_we;
    logic      lo_load;
    logic      hi_load;
    logic      seg_shift;
    logic      seg_calc;
    logic      f_clear;
    logic      f_step;
    logic      pick_lo;
    logic      pick_hi;
    logic      lerp_mul;
    logic [1:0] comp;
    logic      div_load;
    logic      div_step;
    logic      lerp_fin;
    logic      tbl_we;
    tbl_wsel_e tbl_wsel;
    logic      bin_mul;
    logic      bin_sum;
    logic      bin_out;
    logic      out_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic freq_le_last;
    logic bin_oor;
    logic f_gt_hi;
    logic f_le_lo;
    logic f_ge_hi;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/beqsg_dp.sv =====
// ----------------------------------------------------------------------------
// Breakpoint equaliser datapath
// Breakpoint store, gain table, interpolation divider and bin multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module beqsg_dp #(
  parameter int MAX_FFT_LEN = beqsg_pkg::MaxFftLen,
  parameter int MAX_POINTS  = beqsg_pkg::MaxPoints
) (
  input  wire logic                                  clk_i,
  input  wire beqsg_pkg::ctrl_cmd_t                  cmd_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0]         pt_waddr_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0]         pt_raddr_i,
  input  wire logic [$clog2(MAX_FFT_LEN)-1:0]        tbl_waddr_i,
  input  wire logic [$clog2(MAX_FFT_LEN):0]          len_i,
  input  wire logic [beqsg_pkg::FreqW-1:0]           bin_width_i,
  input  wire logic                                  complex_mode_i,
  input  wire logic [beqsg_pkg::FreqW-1:0]           point_freq_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0]    gain_left_re_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0]    gain_left_im_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0]    gain_right_re_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0]    gain_right_im_i,
  input  wire logic [beqsg_pkg::BinW-1:0]            bin_index_i,
  input  wire logic signed [beqsg_pkg::SpecW-1:0]    spec_re_i,
  input  wire logic signed [beqsg_pkg::SpecW-1:0]    spec_im_i,
  output beqsg_pkg::dp_sts_t                         sts_o,
  output logic signed [beqsg_pkg::SpecW-1:0]         out_re_o,
  output logic signed [beqsg_pkg::SpecW-1:0]         out_im_o
);

  localparam int AW  = $clog2(MAX_FFT_LEN);
  localparam int FW  = beqsg_pkg::FreqW + AW;
  localparam int IW  = (AW + 1 > beqsg_pkg::BinW) ? AW + 1 : beqsg_pkg::BinW;
  localparam int GW  = beqsg_pkg::GainW;
  localparam int FrW = beqsg_pkg::FreqW;
  localparam int PtW = FrW + 4 * GW;
  localparam int PrW = GW + 1 + FrW;
  localparam int NW  = PrW + 1;
  localparam int RW  = FrW + 2;
  localparam int MW  = beqsg_pkg::SpecW + GW;
  localparam int SW  = MW + 1;

  logic [PtW-1:0]  pt_mem [MAX_POINTS];
  logic [PtW-1:0]  pt_rd_q;
  logic [31:0]     tbl_mem [MAX_FFT_LEN];
  logic [31:0]     tbl_rd_q;
  logic [31:0]     tbl_wdata;

  logic [FrW-1:0]  last_freq_q;
  logic [FrW-1:0]  lo_f_q, hi_f_q;
  logic [GW-1:0]   lo_g_q [4];
  logic [GW-1:0]   hi_g_q [4];
  logic [GW-1:0]   g_q [4];
  logic [FW-1:0]   f_q;
  logic [FrW-1:0]  num_q, den_q;

  logic [GW-1:0]   y1_q;
  logic            neg_q;
  logic [PrW-1:0]  prod_q;
  logic [RW-1:0]   rem_q;
  logic [GW-1:0]   nlo_q;
  logic [GW-1:0]   quo_q;

  logic [GW:0]     diff;
  logic [GW:0]     mag;
  logic [NW-1:0]   nval;
  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   dvsr;
  logic [GW:0]     lerp_res;

  logic [beqsg_pkg::BinW-1:0]        bin_q;
  logic signed [beqsg_pkg::SpecW-1:0] sr_q, si_q;
  logic signed [GW-1:0]              gr, gi;
  logic signed [MW-1:0]              p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [SW-1:0]              sum_re_q, sum_im_q;

  function automatic logic [beqsg_pkg::SpecW-1:0] rnd_sat(input logic signed [SW-1:0] x);
    logic          neg;
    logic [SW-1:0] m;
    logic [SW-13:0] q;
    neg = x[SW-1];
    m   = neg ? SW'(-x) : SW'(x);
    q   = (SW-12)'((m + SW'(2048)) >> 12);
    if (!neg && q > (SW-12)'(8388607)) return 24'h7FFFFF;
    if (neg && q > (SW-12)'(8388608)) return 24'h800000;
    return neg ? 24'(-q) : q[beqsg_pkg::SpecW-1:0];
  endfunction

  // Status towards the controller.
  assign sts_o.freq_le_last = (point_freq_i <= last_freq_q);
  assign sts_o.bin_oor      = (IW'(bin_index_i) >= IW'(len_i));
  assign sts_o.f_gt_hi      = (f_q > FW'(hi_f_q));
  assign sts_o.f_le_lo      = (f_q <= FW'(lo_f_q));
  assign sts_o.f_ge_hi      = (f_q >= FW'(hi_f_q));

  // Breakpoint store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_we) begin
      pt_mem[pt_waddr_i] <= {point_freq_i, gain_right_im_i, gain_right_re_i,
                             gain_left_im_i, gain_left_re_i};
      last_freq_q        <= point_freq_i;
    end
    pt_rd_q <= pt_mem[pt_raddr_i];
  end

  // Gain table.
  always_comb begin
    unique case (cmd_i.tbl_wsel)
      beqsg_pkg::WSEL_LEFT:  tbl_wdata = {g_q[1], g_q[0]};
      beqsg_pkg::WSEL_RIGHT: tbl_wdata = {g_q[3], g_q[2]};
      default:               tbl_wdata = {{GW{1'b0}}, beqsg_pkg::OneQ12};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_we) begin
      tbl_mem[tbl_waddr_i] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[AW'(bin_q)];
  end

  // Segment tracking and interpolation.
  assign diff     = {hi_g_q[cmd_i.comp][GW-1], hi_g_q[cmd_i.comp]}
                  - {lo_g_q[cmd_i.comp][GW-1], lo_g_q[cmd_i.comp]};
  assign mag      = diff[GW] ? (GW+1)'(-diff) : diff;
  assign nval     = {prod_q, 1'b0} + NW'(den_q);
  assign dvsr     = {1'b0, den_q, 1'b0};
  assign rem_sh   = {rem_q[RW-2:0], nlo_q[GW-1]};
  assign lerp_res = neg_q ? ({y1_q[GW-1], y1_q} - {1'b0, quo_q})
                          : ({y1_q[GW-1], y1_q} + {1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.lo_load) begin
      lo_f_q <= pt_rd_q[PtW-1 -: FrW];
      for (int c = 0; c < 4; c++) lo_g_q[c] <= pt_rd_q[c*GW +: GW];
    end
    if (cmd_i.hi_load || cmd_i.seg_shift) begin
      hi_f_q <= pt_rd_q[PtW-1 -: FrW];
      for (int c = 0; c < 4; c++) hi_g_q[c] <= pt_rd_q[c*GW +: GW];
    end
    if (cmd_i.seg_shift) begin
      lo_f_q <= hi_f_q;
      for (int c = 0; c < 4; c++) lo_g_q[c] <= hi_g_q[c];
    end
    if (cmd_i.f_clear) begin
      f_q <= '0;
    end else if (cmd_i.f_step) begin
      f_q <= f_q + FW'(bin_width_i);
    end
    if (cmd_i.seg_calc) begin
      num_q <= FrW'(f_q - FW'(lo_f_q));
      den_q <= hi_f_q - lo_f_q;
    end
    if (cmd_i.pick_lo) begin
      for (int c = 0; c < 4; c++) g_q[c] <= lo_g_q[c];
    end
    if (cmd_i.pick_hi) begin
      for (int c = 0; c < 4; c++) g_q[c] <= hi_g_q[c];
    end
    if (cmd_i.lerp_mul) begin
      prod_q <= PrW'(mag) * PrW'(num_q);
      neg_q  <= diff[GW];
      y1_q   <= lo_g_q[cmd_i.comp];
    end
    if (cmd_i.div_load) begin
      rem_q <= nval[NW-1 -: RW];
      nlo_q <= nval[GW-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      nlo_q <= {nlo_q[GW-2:0], 1'b0};
      if (rem_sh >= dvsr) begin
        rem_q <= rem_sh - dvsr;
        quo_q <= {quo_q[GW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[GW-2:0], 1'b0};
      end
    end
    if (cmd_i.lerp_fin) begin
      g_q[cmd_i.comp] <= lerp_res[GW-1:0];
    end
  end

  // Bin weighting.
  assign gr = tbl_rd_q[GW-1:0];
  assign gi = tbl_rd_q[2*GW-1:GW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      bin_q <= bin_index_i;
      sr_q  <= spec_re_i;
      si_q  <= spec_im_i;
    end
    if (cmd_i.bin_mul) begin
      p_rr_q <= sr_q * gr;
      p_ii_q <= si_q * gi;
      p_ri_q <= sr_q * gi;
      p_ir_q <= si_q * gr;
    end
    if (cmd_i.bin_sum) begin
      sum_re_q <= complex_mode_i ? (SW'(p_rr_q) - SW'(p_ii_q)) : SW'(p_rr_q);
      sum_im_q <= complex_mode_i ? (SW'(p_ri_q) + SW'(p_ir_q)) : SW'(p_ir_q);
    end
    if (cmd_i.out_zero) begin
      out_re_o <= '0;
      out_im_o <= '0;
    end else if (cmd_i.bin_out) begin
      out_re_o <= rnd_sat(sum_re_q);
      out_im_o <= rnd_sat(sum_im_q);
    end
  end

endmodule

`default_nettype wire

// ===== design/beqsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Breakpoint equaliser controller
// Sequences table clearing, breakpoint loading, table rebuild and bin items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module beqsg_ctrl #(
  parameter int MAX_FFT_LEN = beqsg_pkg::MaxFftLen,
  parameter int MAX_POINTS  = beqsg_pkg::MaxPoints
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic                              op_i,
  input  wire logic                              last_point_i,
  input  wire logic [$clog2(MAX_FFT_LEN)-1:0]    half_i,
  input  wire beqsg_pkg::dp_sts_t                sts_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic [beqsg_pkg::StatW-1:0]            status_o,
  output beqsg_pkg::ctrl_cmd_t                   cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]          pt_waddr_o,
  output logic [$clog2(MAX_POINTS)-1:0]          pt_raddr_o,
  output logic [$clog2(MAX_FFT_LEN)-1:0]         tbl_waddr_o
);

  localparam int AW = $clog2(MAX_FFT_LEN);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = $clog2(beqsg_pkg::DivSteps);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_BRD   = 5'd2;
  localparam logic [4:0] S_BMUL  = 5'd3;
  localparam logic [4:0] S_BSUM  = 5'd4;
  localparam logic [4:0] S_BOUT  = 5'd5;
  localparam logic [4:0] S_RB0   = 5'd6;
  localparam logic [4:0] S_RB1   = 5'd7;
  localparam logic [4:0] S_RB2   = 5'd8;
  localparam logic [4:0] S_CMP   = 5'd9;
  localparam logic [4:0] S_ADV   = 5'd10;
  localparam logic [4:0] S_LMUL  = 5'd11;
  localparam logic [4:0] S_LDIV0 = 5'd12;
  localparam logic [4:0] S_LDIV  = 5'd13;
  localparam logic [4:0] S_LFIN  = 5'd14;
  localparam logic [4:0] S_WRL   = 5'd15;
  localparam logic [4:0] S_WRR   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, cnt_new;
  logic          oe_q, oe_d, ovf_q, ovf_d, oe_new, ovf_new;
  logic [PW-1:0] k_q, k_d;
  logic [AW-1:0] i_q, i_d;
  logic [1:0]    comp_q, comp_d;
  logic [DW-1:0] dstep_q, dstep_d;
  logic          done_q, done_d;
  logic [beqsg_pkg::StatW-1:0] status_q, status_d, st_new;

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign pt_waddr_o = cnt_q[PW-1:0];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    oe_d     = oe_q;
    ovf_d    = ovf_q;
    k_d      = k_q;
    i_d      = i_q;
    comp_d   = comp_q;
    dstep_d  = dstep_q;
    done_d   = 1'b0;
    status_d = status_q;
    cnt_new  = cnt_q;
    oe_new   = oe_q;
    ovf_new  = ovf_q;
    st_new   = beqsg_pkg::ST_OK;
    cmd_o    = '0;
    cmd_o.comp     = comp_q;
    cmd_o.tbl_wsel = beqsg_pkg::WSEL_FILL;
    pt_raddr_o  = k_q;
    tbl_waddr_o = i_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i && (op_i == beqsg_pkg::OP_BIN)) begin
          cmd_o.in_latch = 1'b1;
          if (sts_i.bin_oor) begin
            cmd_o.out_zero = 1'b1;
            done_d         = 1'b1;
            status_d       = beqsg_pkg::ST_BIN_RANGE;
          end else begin
            state_d = S_BRD;
          end
        end else if (start_i) begin
          cmd_o.in_latch = 1'b1;
          cmd_o.out_zero = 1'b1;
          if (cnt_q == CW'(MAX_POINTS)) begin
            ovf_new = 1'b1;
            st_new  = beqsg_pkg::ST_MANY;
          end else begin
            if ((cnt_q != '0) && sts_i.freq_le_last) begin
              oe_new = 1'b1;
              st_new = beqsg_pkg::ST_ORDER;
            end
            cmd_o.pt_we = 1'b1;
            cnt_new     = cnt_q + CW'(1);
          end
          done_d = 1'b1;
          cnt_d  = cnt_new;
          oe_d   = oe_new;
          ovf_d  = ovf_new;
          if (last_point_i) begin
            cnt_d = '0;
            oe_d  = 1'b0;
            ovf_d = 1'b0;
            priority if (cnt_new < CW'(2)) begin
              st_new = beqsg_pkg::ST_FEW;
            end else if (oe_new) begin
              st_new = beqsg_pkg::ST_ORDER;
            end else if (ovf_new) begin
              st_new = beqsg_pkg::ST_MANY;
            end else begin
              st_new  = beqsg_pkg::ST_OK;
              done_d  = 1'b0;
              n_d     = cnt_new;
              state_d = S_RB0;
            end
          end
          status_d = st_new;
        end
      end
      S_CLR: begin
        cmd_o.tbl_we = 1'b1;
        i_d          = i_q + AW'(1);
        if (i_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_BRD:  state_d = S_BMUL;
      S_BMUL: begin
        cmd_o.bin_mul = 1'b1;
        state_d       = S_BSUM;
      end
      S_BSUM: begin
        cmd_o.bin_sum = 1'b1;
        state_d       = S_BOUT;
      end
      S_BOUT: begin
        cmd_o.bin_out = 1'b1;
        done_d        = 1'b1;
        status_d      = beqsg_pkg::ST_OK;
        state_d       = S_IDLE;
      end
      S_RB0: begin
        cmd_o.f_clear = 1'b1;
        i_d           = '0;
        pt_raddr_o    = '0;
        state_d       = S_RB1;
      end
      S_RB1: begin
        cmd_o.lo_load = 1'b1;
        pt_raddr_o    = PW'(1);
        state_d       = S_RB2;
      end
      S_RB2: begin
        cmd_o.hi_load = 1'b1;
        k_d           = PW'(1);
        state_d       = S_CMP;
      end
      S_CMP: begin
        priority if (sts_i.f_gt_hi && ((CW'(k_q) + CW'(1)) < n_q)) begin
          pt_raddr_o = k_q + PW'(1);
          state_d    = S_ADV;
        end else if (sts_i.f_le_lo) begin
          cmd_o.pick_lo = 1'b1;
          state_d       = S_WRL;
        end else if (sts_i.f_ge_hi) begin
          cmd_o.pick_hi = 1'b1;
          state_d       = S_WRL;
        end else begin
          cmd_o.seg_calc = 1'b1;
          comp_d         = '0;
          state_d        = S_LMUL;
        end
      end
      S_ADV: begin
        cmd_o.seg_shift = 1'b1;
        k_d             = k_q + PW'(1);
        state_d         = S_CMP;
      end
      S_LMUL: begin
        cmd_o.lerp_mul = 1'b1;
        state_d        = S_LDIV0;
      end
      S_LDIV0: begin
        cmd_o.div_load = 1'b1;
        dstep_d        = '0;
        state_d        = S_LDIV;
      end
      S_LDIV: begin
        cmd_o.div_step = 1'b1;
        dstep_d        = dstep_q + DW'(1);
        if (dstep_q == DW'(beqsg_pkg::DivSteps - 1)) begin
          state_d = S_LFIN;
        end
      end
      S_LFIN: begin
        cmd_o.lerp_fin = 1'b1;
        if (comp_q == 2'd3) begin
          state_d = S_WRL;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_LMUL;
        end
      end
      S_WRL: begin
        cmd_o.tbl_we   = 1'b1;
        cmd_o.tbl_wsel = beqsg_pkg::WSEL_LEFT;
        state_d        = S_WRR;
      end
      S_WRR: begin
        cmd_o.tbl_we   = 1'b1;
        cmd_o.tbl_wsel = beqsg_pkg::WSEL_RIGHT;
        tbl_waddr_o    = half_i + i_q;
        if (i_q == half_i - AW'(1)) begin
          state_d = S_DONE;
        end else begin
          i_d          = i_q + AW'(1);
          cmd_o.f_step = 1'b1;
          state_d      = S_CMP;
        end
      end
      S_DONE: begin
        cmd_o.out_zero = 1'b1;
        done_d         = 1'b1;
        status_d       = beqsg_pkg::ST_OK;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      n_q      <= '0;
      oe_q     <= 1'b0;
      ovf_q    <= 1'b0;
      k_q      <= '0;
      i_q      <= '0;
      comp_q   <= '0;
      dstep_q  <= '0;
      done_q   <= 1'b0;
      status_q <= beqsg_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      oe_q     <= oe_d;
      ovf_q    <= ovf_d;
      k_q      <= k_d;
      i_q      <= i_d;
      comp_q   <= comp_d;
      dstep_q  <= dstep_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/breakpoint_eq_spectrum_gain.sv =====
// ----------------------------------------------------------------------------
// Breakpoint spectral equaliser, top level
// Stereo per-bin complex gain built from interpolated frequency breakpoints.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  item in   input      start_i high, busy_o low   op_i .. spec_im_i
//  result    output     done_o, one cycle          out_re_o, out_im_o, status_o
//  config    input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A load item that does not close the list, a closing item that fails its
// checks and an out-of-range bin each give their result in the cycle after
// acceptance, and the block can take the next item in that same cycle.
// A bin item passes through table read, products, sum and rounding.
// A valid closing item rebuilds the table; each bin needs segment compares
// plus, inside a segment, four interpolations that share the single
// one-bit-per-cycle divider. After reset the gain table is filled with
// unity gain, one entry a cycle, and busy_o stays high until every entry
// is written. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_eq_spectrum_gain #(
  parameter int MAX_FFT_LEN = beqsg_pkg::MaxFftLen,
  parameter int MAX_POINTS  = beqsg_pkg::MaxPoints
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [beqsg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [beqsg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                               op_i,
  input  wire logic [beqsg_pkg::FreqW-1:0]        point_freq_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0] gain_left_re_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0] gain_left_im_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0] gain_right_re_i,
  input  wire logic signed [beqsg_pkg::GainW-1:0] gain_right_im_i,
  input  wire logic                               last_point_i,
  input  wire logic [beqsg_pkg::BinW-1:0]         bin_index_i,
  input  wire logic signed [beqsg_pkg::SpecW-1:0] spec_re_i,
  input  wire logic signed [beqsg_pkg::SpecW-1:0] spec_im_i,
  output logic                                    done_o,
  output logic signed [beqsg_pkg::SpecW-1:0]      out_re_o,
  output logic signed [beqsg_pkg::SpecW-1:0]      out_im_o,
  output logic [beqsg_pkg::StatW-1:0]             status_o
);

  localparam int AW = $clog2(MAX_FFT_LEN);
  localparam int PW = $clog2(MAX_POINTS);
  localparam logic [beqsg_pkg::LogW-1:0] LogMax = beqsg_pkg::LogW'(AW);

  // Configuration registers, written by the user only while the block is idle; not enforced here.
  logic [beqsg_pkg::LogW-1:0]  fft_lg_q;
  logic [beqsg_pkg::FreqW-1:0] bin_width_q;
  logic                        cmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fft_lg_q    <= beqsg_pkg::RstFftLenLog2;
      bin_width_q <= beqsg_pkg::RstBinWidth;
      cmode_q     <= beqsg_pkg::RstComplex;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        beqsg_pkg::CFG_FFT_LEN_LOG2: fft_lg_q    <= cfg_data_i[beqsg_pkg::LogW-1:0];
        beqsg_pkg::CFG_BIN_WIDTH:    bin_width_q <= cfg_data_i;
        beqsg_pkg::CFG_COMPLEX_MODE: cmode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The effective length is clamped below at 64 bins and above at the
  // table depth; each channel uses half of it.
  logic [beqsg_pkg::LogW-1:0] lg_lo, lg_eff;
  logic [AW:0]                len;
  logic [AW-1:0]              half;

  assign lg_lo  = (fft_lg_q < beqsg_pkg::MinFftLog) ? beqsg_pkg::MinFftLog : fft_lg_q;
  assign lg_eff = (lg_lo > LogMax) ? LogMax : lg_lo;
  assign len    = (AW+1)'(1) << lg_eff;
  assign half   = len[AW:1];

  beqsg_pkg::ctrl_cmd_t cmd;
  beqsg_pkg::dp_sts_t   sts;
  logic [PW-1:0]        pt_waddr, pt_raddr;
  logic [AW-1:0]        tbl_waddr;

  beqsg_ctrl #(
    .MAX_FFT_LEN (MAX_FFT_LEN),
    .MAX_POINTS  (MAX_POINTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .last_point_i (last_point_i),
    .half_i       (half),
    .sts_i        (sts),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .status_o     (status_o),
    .cmd_o        (cmd),
    .pt_waddr_o   (pt_waddr),
    .pt_raddr_o   (pt_raddr),
    .tbl_waddr_o  (tbl_waddr)
  );

  beqsg_dp #(
    .MAX_FFT_LEN (MAX_FFT_LEN),
    .MAX_POINTS  (MAX_POINTS)
  ) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .pt_waddr_i      (pt_waddr),
    .pt_raddr_i      (pt_raddr),
    .tbl_waddr_i     (tbl_waddr),
    .len_i           (len),
    .bin_width_i     (bin_width_q),
    .complex_mode_i  (cmode_q),
    .point_freq_i    (point_freq_i),
    .gain_left_re_i  (gain_left_re_i),
    .gain_left_im_i  (gain_left_im_i),
    .gain_right_re_i (gain_right_re_i),
    .gain_right_im_i (gain_right_im_i),
    .bin_index_i     (bin_index_i),
    .spec_re_i       (spec_re_i),
    .spec_im_i       (spec_im_i),
    .sts_o           (sts),
    .out_re_o        (out_re_o),
    .out_im_o        (out_im_o)
  );

endmodule

`default_nettype wire

// ===== design/beqsg_checker.sv =====
// ----------------------------------------------------------------------------
// Breakpoint equaliser port checker
// Watches the top-level ports for result timing and status consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module beqsg_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start_i,
  input wire logic                               busy_o,
  input wire logic                               op_i,
  input wire logic                               last_point_i,
  input wire logic                               done_o,
  input wire logic [beqsg_pkg::StatW-1:0]        status_o,
  input wire logic signed [beqsg_pkg::SpecW-1:0] out_re_o,
  input wire logic signed [beqsg_pkg::SpecW-1:0] out_im_o
);

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= beqsg_pkg::ST_BIN_RANGE))
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != beqsg_pkg::ST_OK)) |-> (out_re_o == '0 && out_im_o == '0))
    else $error("error result carries non-zero data");

  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (op_i == beqsg_pkg::OP_LOAD) && !last_point_i) |=> done_o)
    else $error("open load item gave no result in the next cycle");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result without an item");

endmodule

bind breakpoint_eq_spectrum_gain beqsg_checker u_beqsg_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Breakpoint equaliser testbench
// Sends load and bin items through the start/busy handshake and writes the
// registers between phases. A behavioural model of the breakpoint store and
// the gain table predicts every result. A checker compares each done_o
// strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import beqsg_pkg::*;

  // Each result is compared against an in-order list of predictions of this form.
  typedef struct {
    logic signed [SpecW-1:0] re;
    logic signed [SpecW-1:0] im;
    logic [StatW-1:0]        st;
  } eq_result_t;

  typedef struct {
    logic                    op;
    logic [FreqW-1:0]        freq;
    logic signed [GainW-1:0] glr, gli, grr, gri;
    logic                    last;
    logic [BinW-1:0]         bin;
    logic signed [SpecW-1:0] sre, sim;
  } eq_item_t;

  localparam int WatchdogLimit = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic op_i = 1'b0;
  logic [FreqW-1:0] point_freq_i = '0;
  logic signed [GainW-1:0] gain_left_re_i = '0, gain_left_im_i = '0;
  logic signed [GainW-1:0] gain_right_re_i = '0, gain_right_im_i = '0;
  logic last_point_i = 1'b0;
  logic [BinW-1:0] bin_index_i = '0;
  logic signed [SpecW-1:0] spec_re_i = '0, spec_im_i = '0;
  logic done_o;
  logic signed [SpecW-1:0] out_re_o, out_im_o;
  logic [StatW-1:0] status_o;

  breakpoint_eq_spectrum_gain dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Model state: registers, breakpoint store and the per-bin gain table.
  // Gains are packed with the real part in the low half.
  logic [LogW-1:0]  mdl_fft_log;
  logic [FreqW-1:0] mdl_bin_width;
  logic             mdl_complex;
  logic [FreqW-1:0] pt_freq [MaxPoints];
  logic [31:0]      pt_gain_l [MaxPoints];
  logic [31:0]      pt_gain_r [MaxPoints];
  int unsigned      pt_count;
  bit               pt_order_err, pt_overflow;
  logic [31:0]      gain_table [MaxFftLen];

  eq_result_t pending_results[$];
  int  fail_count = 0;
  int  sent_items = 0;
  bit  gaps_on = 1'b1;
  bit  accepted_now;
  int  idle_cycles = 0;

  function automatic int unsigned table_len();
    int unsigned lg;
    int unsigned len;
    lg = mdl_fft_log;
    if (lg < 6) lg = 6;
    if (lg > 15) lg = 15;
    len = 1 << lg;
    while (len > MaxFftLen) len >>= 1;
    return len;
  endfunction

  function automatic longint lerp_gain(longint y1, longint y2, longint num, longint den);
    longint diff;
    longint mag;
    longint q;
    diff = y2 - y1;
    mag = (diff < 0) ? -diff : diff;
    q = (2 * mag * num + den) / (2 * den);
    return (diff < 0) ? y1 - q : y1 + q;
  endfunction

  function automatic logic [31:0] gain_at_freq(bit right, longint f);
    logic [31:0] g [MaxPoints];
    int unsigned n;
    longint f1, den;
    logic signed [GainW-1:0] ar, ai, br, bi;
    logic [GainW-1:0] qr, qi;
    if (right) g = pt_gain_r;
    else g = pt_gain_l;
    n = pt_count;
    if (f <= pt_freq[0]) return g[0];
    if (f >= pt_freq[n-1]) return g[n-1];
    for (int j = 1; j < n; j++) begin
      if (pt_freq[j] == f) return g[j];
      if (pt_freq[j] > f) begin
        f1 = pt_freq[j-1];
        den = longint'(pt_freq[j]) - f1;
        ar = g[j-1][15:0]; ai = g[j-1][31:16];
        br = g[j][15:0];   bi = g[j][31:16];
        qr = GainW'(lerp_gain(ar, br, f - f1, den));
        qi = GainW'(lerp_gain(ai, bi, f - f1, den));
        return {qi, qr};
      end
    end
    return g[n-1];
  endfunction

  function automatic logic signed [SpecW-1:0] round_sat(longint x);
    longint m;
    longint r;
    m = (x < 0) ? -x : x;
    r = (m + 2048) >>> 12;
    if (x < 0) r = -r;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return SpecW'(r);
  endfunction

  // Works out the result of one accepted item and moves the model on.
  function automatic eq_result_t equalise_item(eq_item_t it);
    eq_result_t res;
    int unsigned half;
    logic signed [GainW-1:0] gr, gi;
    longint sr, si;
    res.re = '0;
    res.im = '0;
    res.st = ST_OK;
    if (it.op == OP_LOAD) begin
      if (pt_count >= MaxPoints) begin
        pt_overflow = 1'b1;
        res.st = ST_MANY;
      end else begin
        if (pt_count > 0 && it.freq <= pt_freq[pt_count-1]) begin
          pt_order_err = 1'b1;
          res.st = ST_ORDER;
        end
        pt_freq[pt_count]   = it.freq;
        pt_gain_l[pt_count] = {it.gli, it.glr};
        pt_gain_r[pt_count] = {it.gri, it.grr};
        pt_count++;
      end
      if (it.last) begin
        if (pt_count < 2) res.st = ST_FEW;
        else if (pt_order_err) res.st = ST_ORDER;
        else if (pt_overflow) res.st = ST_MANY;
        else begin
          half = table_len() / 2;
          for (int i = 0; i < half; i++) begin
            gain_table[i]        = gain_at_freq(1'b0, longint'(mdl_bin_width) * i);
            gain_table[half + i] = gain_at_freq(1'b1, longint'(mdl_bin_width) * i);
          end
          res.st = ST_OK;
        end
        pt_count = 0;
        pt_order_err = 1'b0;
        pt_overflow = 1'b0;
      end
    end else if (it.bin >= table_len()) begin
      res.st = ST_BIN_RANGE;
    end else begin
      gr = gain_table[it.bin][15:0];
      gi = gain_table[it.bin][31:16];
      sr = it.sre;
      si = it.sim;
      if (mdl_complex) begin
        res.re = round_sat(sr * gr - si * gi);
        res.im = round_sat(sr * gi + si * gr);
      end else begin
        res.re = round_sat(sr * gr);
        res.im = round_sat(si * gr);
      end
    end
    return res;
  endfunction

  // Every field is random; callers then fix the ones that matter.
  function automatic eq_item_t random_item(logic op);
    eq_item_t it;
    it.op   = op;
    it.freq = FreqW'($urandom);
    it.glr  = GainW'($urandom);
    it.gli  = GainW'($urandom);
    it.grr  = GainW'($urandom);
    it.gri  = GainW'($urandom);
    it.last = 1'($urandom);
    it.bin  = BinW'($urandom);
    it.sre  = SpecW'($urandom);
    it.sim  = SpecW'($urandom);
    return it;
  endfunction

  function automatic eq_item_t point_item(logic [FreqW-1:0] f, logic last);
    eq_item_t it;
    it = random_item(OP_LOAD);
    it.freq = f;
    it.last = last;
    return it;
  endfunction

  function automatic eq_item_t bin_item(int unsigned idx);
    eq_item_t it;
    it = random_item(OP_BIN);
    it.bin = BinW'(idx);
    return it;
  endfunction

  // Sends one item. Start stays high after acceptance, so back-to-back items
  // follow without a gap unless a random idle burst is drawn.
  task automatic send_item(eq_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    op_i            <= it.op;
    point_freq_i    <= it.freq;
    gain_left_re_i  <= it.glr;
    gain_left_im_i  <= it.gli;
    gain_right_re_i <= it.grr;
    gain_right_im_i <= it.gri;
    last_point_i    <= it.last;
    bin_index_i     <= it.bin;
    spec_re_i       <= it.sre;
    spec_im_i       <= it.sim;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(equalise_item(it));
    sent_items++;
  endtask

  // Drops start and waits until every result is in and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= CfgDataW'($urandom);
    case (idx)
      CFG_FFT_LEN_LOG2: mdl_fft_log   = data[LogW-1:0];
      CFG_BIN_WIDTH:    mdl_bin_width = data[FreqW-1:0];
      CFG_COMPLEX_MODE: mdl_complex   = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned lg, int unsigned bw, bit cplx);
    write_reg(CFG_FFT_LEN_LOG2, CfgDataW'(lg));
    write_reg(CFG_BIN_WIDTH, CfgDataW'(bw));
    write_reg(CFG_COMPLEX_MODE, CfgDataW'(cplx));
  endtask

  // Reset table is unity gain at the reset length of 512 bins; the
  // extremes of the spectrum must pass unchanged, bins past the end are
  // out of range.
  task automatic test_reset_table();
    eq_item_t it;
    it = bin_item(0);
    it.sre = 24'sh7FFFFF; it.sim = -24'sh800000;
    send_item(it);
    it = bin_item(511);
    it.sre = -24'sh800000; it.sim = 24'sh7FFFFF;
    send_item(it);
    send_item(bin_item(512));
    send_item(bin_item(4095));
    drain();
  endtask

  // List errors: a lone closing point, a repeated frequency, a falling one.
  task automatic test_list_errors();
    send_item(point_item(25'd1000, 1'b1));
    send_item(point_item(25'd1000, 1'b0));
    send_item(point_item(25'd1000, 1'b0));
    send_item(point_item(25'd5000, 1'b1));
    send_item(point_item(25'd9000, 1'b0));
    send_item(point_item(25'd100, 1'b1));
    send_item(bin_item(3));
    drain();
  endtask

  // A full store: the sixty-fifth point and the closing one are dropped and
  // the table must stay as it was.
  task automatic test_overflow();
    for (int i = 0; i < MaxPoints; i++) send_item(point_item(FreqW'(i * 100), 1'b0));
    send_item(point_item(25'd99999, 1'b0));
    send_item(point_item(25'd100000, 1'b1));
    send_item(bin_item(7));
    drain();
  endtask

  // Valid lists at extreme gains and register settings, in both multiply
  // modes, with saturating spectra.
  task automatic test_rebuild_extremes();
    eq_item_t it;
    configure(0, 25'd100, 1'b1);
    it = point_item(25'd150, 1'b0);
    it.glr = 16'sh7FFF; it.gli = -16'sh8000; it.grr = -16'sh8000; it.gri = 16'sh7FFF;
    send_item(it);
    it = point_item(25'd2950, 1'b1);
    it.glr = -16'sh8000; it.gli = 16'sh7FFF; it.grr = 16'sh7FFF; it.gri = -16'sh8000;
    send_item(it);
    for (int i = 0; i < 6; i++) begin
      it = bin_item(i * 13);
      it.sre = (i % 2) ? 24'sh7FFFFF : -24'sh800000;
      it.sim = (i % 3) ? -24'sh800000 : 24'sh7FFFFF;
      send_item(it);
    end
    send_item(bin_item(64));
    drain();
    // Zero bin spacing puts every bin on the first point.
    configure(6, 0, 1'b0);
    send_item(point_item(25'd0, 1'b0));
    send_item(point_item(25'h1FFFFFF, 1'b1));
    send_item(bin_item(5));
    send_item(bin_item(40));
    drain();
    // Lengths past the maximum fold back to 4096 bins; a wide spacing keeps
    // almost every bin above the last point.
    configure(15, 25'h1FFFFFF, 1'b1);
    send_item(point_item(25'd0, 1'b0));
    send_item(point_item(25'h1FFFFFE, 1'b1));
    send_item(bin_item(1));
    send_item(bin_item(4095));
    drain();
    configure(12, 25'h1FFFFFF, 1'b0);
    send_item(bin_item(2049));
    drain();
  endtask

  // Phases of register settings, breakpoint lists and bins. Most lists are
  // well formed so that rebuilds happen; some are broken on purpose.
  task automatic test_random_phases(int unsigned target);
    int unsigned len, span, n, bw;
    int unsigned freqs[$];
    eq_item_t it;
    while (sent_items < target) begin
      case ($urandom_range(0, 3))
        0: bw = $urandom_range(1, 64);
        1: bw = $urandom_range(0, 200000);
        2: bw = $urandom & 25'h1FFFFFF;
        default: bw = $urandom_range(1000, 30000);
      endcase
      configure($urandom_range(0, 7), bw, 1'($urandom));
      len = table_len();
      span = (longint'(bw) * len / 2 > 25'h1FFFFFF) ? 25'h1FFFFFF : bw * len / 2;
      n = $urandom_range(2, 10);
      freqs.delete();
      for (int i = 0; i < n; i++) freqs.push_back($urandom_range(0, span));
      freqs.sort();
      if ($urandom_range(0, 5) == 0) freqs.shuffle();
      else if ($urandom_range(0, 7) == 0) n = 1;
      for (int i = 0; i < n; i++) begin
        it = point_item(FreqW'(freqs[i]), i == n - 1);
        if ($urandom_range(0, 7) == 0) it.glr = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
        send_item(it);
      end
      repeat ($urandom_range(30, 60)) begin
        send_item(bin_item(($urandom_range(0, 15) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, len - 1)));
      end
      drain();
    end
  endtask

  // Final stretch: back-to-back bins with no idling at all.
  task automatic test_streaming();
    gaps_on = 1'b0;
    repeat (100) send_item(bin_item($urandom_range(0, table_len() - 1)));
    drain();
  endtask

  // Result checker: done_o is sampled at the edge that ends its cycle.
  always @(posedge clk_i) begin
    eq_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d status=%0d",
                 $time, out_re_o, out_im_o, status_o);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_re_o !== exp_res.re) begin
          $display("%0t: out_re expected %0d actual %0d", $time, exp_res.re, out_re_o);
          fail_count++;
        end
        if (out_im_o !== exp_res.im) begin
          $display("%0t: out_im expected %0d actual %0d", $time, exp_res.im, out_im_o);
          fail_count++;
        end
        if (status_o !== exp_res.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  // The longest quiet spell is a rebuild of the full table.
  always @(posedge clk_i) begin
    accepted_now = start_i && !busy_o;
    if (accepted_now || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mdl_fft_log   = RstFftLenLog2;
    mdl_bin_width = RstBinWidth;
    mdl_complex   = RstComplex;
    pt_count = 0;
    pt_order_err = 1'b0;
    pt_overflow = 1'b0;
    for (int i = 0; i < MaxFftLen; i++) gain_table[i] = {16'h0000, OneQ12};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // The block clears its table after reset and shows busy until done.
    while (busy_o) @(posedge clk_i);
    test_reset_table();
    test_list_errors();
    test_overflow();
    test_rebuild_extremes();
    test_random_phases(800);
    test_streaming();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/beqsg_pkg.sv
design/beqsg_dp.sv
design/beqsg_ctrl.sv
design/breakpoint_eq_spectrum_gain.sv
design/beqsg_checker.sv
bench/tb_top.sv
